// File: design/efg_pkg.sv
`default_nettype none

package efg_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int TALLY_W      = $clog2(MAX_CHANNELS + 1);

  localparam int SMP_W  = 16;
  localparam int ENV_W  = 23;
  localparam int ACC_W  = 34;
  localparam int LVL_W  = 17;
  localparam int GAIN_W = 16;
  localparam int COEF_W = 24;
  localparam int MUL_W  = 24;
  localparam int PRD_W  = 2 * MUL_W;
  localparam int FLT_W  = COEF_W + ENV_W;
  localparam int CS_W   = 20;
  localparam int CNT_W  = 6;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 3;

  localparam int DIV_STEPS  = ACC_W;
  localparam int SQRT_STEPS = ACC_W / 2;

  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

  localparam logic [ENV_W-1:0]  ENV_MAX  = '1;
  localparam logic [ACC_W-1:0]  ACC_MAX  = '1;
  localparam logic [LVL_W-1:0]  PEAK_CAP = '1;

  localparam logic [GAIN_W-1:0] GAIN_RST    = GAIN_W'(256);
  localparam logic [ENV_W-1:0]  THRESH_RST  = ENV_W'(3277);
  localparam logic [COEF_W-1:0] ATTACK_RST  = COEF_W'(34916);
  localparam logic [COEF_W-1:0] RELEASE_RST = COEF_W'(3495);

  typedef enum logic [IDX_W-1:0] {
    CFG_DETECT_MODE    = 3'd0,
    CFG_INPUT_GAIN     = 3'd1,
    CFG_GATE_THRESHOLD = 3'd2,
    CFG_ATTACK_COEFF   = 3'd3,
    CFG_RELEASE_COEFF  = 3'd4
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD,
    ST_FRAME,
    ST_DIV,
    ST_SQRT,
    ST_GAIN,
    ST_SAT,
    ST_FILT,
    ST_UPD,
    ST_GATE,
    ST_EMIT
  } efg_state_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_value;
    logic                    last_in_frame;
  } in_word_t;

  typedef struct packed {
    logic [ENV_W-1:0] envelope_out;
    logic             gate_out;
  } out_word_t;

  typedef struct packed {
    efg_state_e state;
    logic       step_last;
  } seq_ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic frame_end;
    logic rms_mode;
    logic out_free;
  } seq_stat_t;

endpackage

`default_nettype wire

// File: design/envelope_follower_with_gate_unit.sv
`default_nettype none

// channel   signals                                   direction
// in        in_valid_i, in_ready_o, in_word_i         sample word in
// out       out_valid_o, out_ready_i, out_word_o      envelope/gate word out
// cfg       cfg_valid_i, cfg_ready_o, cfg_index_i,    register write in
//           cfg_data_i
//
// A word without the frame mark passes accept and fold before ready returns.
// A marked word then passes frame, gain, saturate, filter, update, gate and emit.
// RMS mode adds 34 divide and 17 square root steps on the shared compare/subtract unit.
// One 24x24 multiplier is shared by square, gain and filter steps.
// The finished word waits in the output register; a full output register holds
// the sequencer in its last step. Reset clears envelope, gate, frame sums and
// restores config defaults.

module envelope_follower_with_gate_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire efg_pkg::in_word_t          in_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output efg_pkg::out_word_t              out_word_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [efg_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [efg_pkg::CFG_W-1:0]  cfg_data_i
);

  efg_pkg::seq_ctrl_t ctrl;
  efg_pkg::seq_stat_t stat;

  logic                        mode_q;
  logic [efg_pkg::GAIN_W-1:0]  gain_q;
  logic [efg_pkg::ENV_W-1:0]   thresh_q;
  logic [efg_pkg::COEF_W-1:0]  attack_q;
  logic [efg_pkg::COEF_W-1:0]  release_q;

  logic [efg_pkg::ACC_W-1:0]   accum_q, accum_d;
  logic [efg_pkg::TALLY_W-1:0] tally_q, tally_d;
  logic [efg_pkg::ENV_W-1:0]   env_q, env_d;
  logic                        gate_q, gate_d;
  logic                        out_valid_q, out_valid_d;

  logic [efg_pkg::SMP_W-1:0]   sample_q;
  logic                        last_q;
  logic [efg_pkg::ACC_W-1:0]   work_q, work_d;
  logic [efg_pkg::CS_W-1:0]    rem_q, rem_d;
  logic [efg_pkg::LVL_W-1:0]   root_q, root_d;
  logic [efg_pkg::FLT_W-1:0]   prod_q, prod_d;
  logic [efg_pkg::ENV_W-1:0]   det_q, det_d;
  logic                        up_q, up_d;
  efg_pkg::out_word_t          out_q, out_d;

  logic                        in_fire;
  logic [efg_pkg::SMP_W-1:0]   mag;
  logic [efg_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [efg_pkg::PRD_W-1:0]   mul_p;
  logic [efg_pkg::CS_W-1:0]    cs_a, cs_b, cs_diff;
  logic                        cs_ge;
  logic [efg_pkg::TALLY_W-1:0] divisor;
  logic [efg_pkg::ACC_W:0]     sq_sum;
  logic                        det_ge, det_gt;
  logic [efg_pkg::ENV_W-1:0]   env_diff;
  logic [efg_pkg::ENV_W:0]     step_dn;

  assign in_ready_o  = (ctrl.state == efg_pkg::ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign stat.in_fire   = in_fire;
  assign stat.frame_end = last_q;
  assign stat.rms_mode  = mode_q;
  assign stat.out_free  = ~out_valid_q | out_ready_i;

  efg_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  efg_cmpsub u_cmpsub (
    .a_i    (cs_a),
    .b_i    (cs_b),
    .diff_o (cs_diff),
    .ge_o   (cs_ge)
  );

  assign mag     = sample_q[efg_pkg::SMP_W-1] ? (~sample_q + 1'b1) : sample_q;
  assign divisor = (tally_q == '0) ? efg_pkg::TALLY_W'(1) : tally_q;
  assign det_ge  = (det_q >= env_q);
  assign det_gt  = (det_q > env_q);
  assign env_diff = det_ge ? (det_q - env_q) : (env_q - det_q);
  assign sq_sum  = {1'b0, accum_q} + (efg_pkg::ACC_W + 1)'(mul_p[2*efg_pkg::SMP_W-1:0]);
  assign step_dn = {1'b0, prod_q[efg_pkg::FLT_W-1:efg_pkg::COEF_W]}
                 + (efg_pkg::ENV_W + 1)'(|prod_q[efg_pkg::COEF_W-1:0]);

  // shared multiplier operands
  always_comb begin
    case (ctrl.state)
      efg_pkg::ST_FOLD: begin
        mul_a = efg_pkg::MUL_W'(mag);
        mul_b = efg_pkg::MUL_W'(mag);
      end
      efg_pkg::ST_GAIN: begin
        mul_a = efg_pkg::MUL_W'(root_q);
        mul_b = efg_pkg::MUL_W'(gain_q);
      end
      default: begin
        mul_a = det_gt ? attack_q : release_q;
        mul_b = efg_pkg::MUL_W'(env_diff);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // shared compare/subtract operands
  always_comb begin
    if (ctrl.state == efg_pkg::ST_DIV) begin
      cs_a = efg_pkg::CS_W'({rem_q[efg_pkg::TALLY_W-1:0], work_q[efg_pkg::ACC_W-1]});
      cs_b = efg_pkg::CS_W'(divisor);
    end else begin
      cs_a = {rem_q[efg_pkg::CS_W-3:0], work_q[efg_pkg::ACC_W-1 -: 2]};
      cs_b = efg_pkg::CS_W'({root_q, 2'b01});
    end
  end

  always_comb begin
    accum_d     = accum_q;
    tally_d     = tally_q;
    env_d       = env_q;
    gate_d      = gate_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    work_d      = work_q;
    rem_d       = rem_q;
    root_d      = root_q;
    prod_d      = prod_q;
    det_d       = det_q;
    up_d        = up_q;
    out_d       = out_q;
    unique case (ctrl.state)
      efg_pkg::ST_FOLD: begin
        if (tally_q < efg_pkg::TALLY_W'(efg_pkg::MAX_CHANNELS)) begin
          if (!mode_q) begin
            if (efg_pkg::ACC_W'(mag) > accum_q) accum_d = efg_pkg::ACC_W'(mag);
          end else begin
            accum_d = sq_sum[efg_pkg::ACC_W] ? efg_pkg::ACC_MAX
                                             : sq_sum[efg_pkg::ACC_W-1:0];
          end
          tally_d = tally_q + 1'b1;
        end
      end
      efg_pkg::ST_FRAME: begin
        work_d = accum_q;
        rem_d  = '0;
        if (mode_q) begin
          root_d = '0;
        end else if (|accum_q[efg_pkg::ACC_W-1:efg_pkg::LVL_W]) begin
          root_d = efg_pkg::PEAK_CAP;
        end else begin
          root_d = accum_q[efg_pkg::LVL_W-1:0];
        end
      end
      efg_pkg::ST_DIV: begin
        work_d = {work_q[efg_pkg::ACC_W-2:0], cs_ge};
        rem_d  = cs_ge ? cs_diff : cs_a;
        if (ctrl.step_last) begin
          rem_d  = '0;
          root_d = '0;
        end
      end
      efg_pkg::ST_SQRT: begin
        work_d = {work_q[efg_pkg::ACC_W-3:0], 2'b00};
        rem_d  = cs_ge ? cs_diff : cs_a;
        root_d = {root_q[efg_pkg::LVL_W-2:0], cs_ge};
      end
      efg_pkg::ST_GAIN: begin
        prod_d = mul_p[efg_pkg::FLT_W-1:0];
      end
      efg_pkg::ST_SAT: begin
        // level * gain / 256, saturated
        det_d = (|prod_q[efg_pkg::LVL_W+efg_pkg::GAIN_W-1:efg_pkg::ENV_W+8])
              ? efg_pkg::ENV_MAX : prod_q[efg_pkg::ENV_W+7:8];
      end
      efg_pkg::ST_FILT: begin
        prod_d = mul_p[efg_pkg::FLT_W-1:0];
        up_d   = det_ge;
      end
      efg_pkg::ST_UPD: begin
        // floor toward minus infinity on the way down
        env_d = up_q ? (env_q + prod_q[efg_pkg::FLT_W-1:efg_pkg::COEF_W])
                     : (env_q - step_dn[efg_pkg::ENV_W-1:0]);
      end
      efg_pkg::ST_GATE: begin
        if (!gate_q) begin
          gate_d = (env_q >= thresh_q);
        end else if ({env_q, 1'b0} < {1'b0, thresh_q}) begin
          gate_d = 1'b0;
        end
      end
      efg_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          out_d.envelope_out = env_q;
          out_d.gate_out     = gate_q;
          out_valid_d        = 1'b1;
          accum_d            = '0;
          tally_d            = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      gain_q      <= efg_pkg::GAIN_RST;
      thresh_q    <= efg_pkg::THRESH_RST;
      attack_q    <= efg_pkg::ATTACK_RST;
      release_q   <= efg_pkg::RELEASE_RST;
      accum_q     <= '0;
      tally_q     <= '0;
      env_q       <= '0;
      gate_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      accum_q     <= accum_d;
      tally_q     <= tally_d;
      env_q       <= env_d;
      gate_q      <= gate_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          efg_pkg::CFG_DETECT_MODE:    mode_q    <= cfg_data_i[0];
          efg_pkg::CFG_INPUT_GAIN:     gain_q    <= cfg_data_i[efg_pkg::GAIN_W-1:0];
          efg_pkg::CFG_GATE_THRESHOLD: thresh_q  <= cfg_data_i[efg_pkg::ENV_W-1:0];
          efg_pkg::CFG_ATTACK_COEFF:   attack_q  <= cfg_data_i[efg_pkg::COEF_W-1:0];
          efg_pkg::CFG_RELEASE_COEFF:  release_q <= cfg_data_i[efg_pkg::COEF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_word_i.sample_value;
      last_q   <= in_word_i.last_in_frame;
    end
    work_q <= work_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    prod_q <= prod_d;
    det_q  <= det_d;
    up_q   <= up_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

// File: design/efg_cmpsub.sv
`default_nettype none

module efg_cmpsub (
  input  wire logic [efg_pkg::CS_W-1:0] a_i,
  input  wire logic [efg_pkg::CS_W-1:0] b_i,
  output logic      [efg_pkg::CS_W-1:0] diff_o,
  output logic                          ge_o
);

  logic [efg_pkg::CS_W:0] sub;

  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = sub[efg_pkg::CS_W-1:0];
  assign ge_o   = ~sub[efg_pkg::CS_W];

endmodule

`default_nettype wire

// File: design/efg_seq.sv
`default_nettype none

module efg_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire efg_pkg::seq_stat_t stat_i,
  output efg_pkg::seq_ctrl_t      ctrl_o
);

  efg_pkg::efg_state_e state_q, state_d;
  logic [efg_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efg_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      efg_pkg::ST_IDLE: begin
        if (stat_i.in_fire) state_d = efg_pkg::ST_FOLD;
      end
      efg_pkg::ST_FOLD: begin
        state_d = stat_i.frame_end ? efg_pkg::ST_FRAME : efg_pkg::ST_IDLE;
      end
      efg_pkg::ST_FRAME: begin
        if (stat_i.rms_mode) begin
          state_d = efg_pkg::ST_DIV;
          cnt_d   = efg_pkg::DIV_LAST;
        end else begin
          state_d = efg_pkg::ST_GAIN;
        end
      end
      efg_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = efg_pkg::ST_SQRT;
          cnt_d   = efg_pkg::SQRT_LAST;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      efg_pkg::ST_SQRT: begin
        if (cnt_q == '0) begin
          state_d = efg_pkg::ST_GAIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      efg_pkg::ST_GAIN: state_d = efg_pkg::ST_SAT;
      efg_pkg::ST_SAT:  state_d = efg_pkg::ST_FILT;
      efg_pkg::ST_FILT: state_d = efg_pkg::ST_UPD;
      efg_pkg::ST_UPD:  state_d = efg_pkg::ST_GATE;
      efg_pkg::ST_GATE: state_d = efg_pkg::ST_EMIT;
      efg_pkg::ST_EMIT: begin
        if (stat_i.out_free) state_d = efg_pkg::ST_IDLE;
      end
      default: state_d = efg_pkg::ST_IDLE;
    endcase
  end

  assign ctrl_o.state     = state_q;
  assign ctrl_o.step_last = (cnt_q == '0);

endmodule

`default_nettype wire
